>>> hdl/varint_length_prefixed_deframer_core_macros.svh
// Assertion macros shared by the deframer's RTL files.
// Needs a clock named clock and a reset named reset in the module that uses them.
`ifndef VARINT_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH
`define VARINT_LENGTH_PREFIXED_DEFRAMER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VLPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/vlpd_pkg.sv
// Shared types and constants of the varint length-prefixed deframer.
// No dependencies; the core, the input stage and the parser import it.
package vlpd_pkg;

   localparam logic [7:0] PREAMBLE_BYTE    = 8'h00;
   localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

   typedef enum logic [1:0] {
      KIND_PAYLOAD      = 2'd0,
      KIND_EMPTY        = 2'd1,
      KIND_BAD_PREAMBLE = 2'd2,
      KIND_OVERLONG     = 2'd3
   } kind_type;

   // One registered received byte between the input stage and the parser.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } stage_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [31:0] message_type;
      logic        last_of_packet;
   } result_type;

endpackage

>>> hdl/vlpd_req_if.sv
// Input channel of the deframer: one received byte per item.
// Depends on nothing.
interface vlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

>>> hdl/vlpd_rsp_if.sv
// Result channel of the deframer: one result item per handshake.
// Depends on nothing.
interface vlpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  payload_byte;
   logic [31:0] message_type;
   logic        last_of_packet;

   modport source (output valid, output out_kind, output payload_byte,
                   output message_type, output last_of_packet, input ready);
   modport sink (input valid, input out_kind, input payload_byte,
                 input message_type, input last_of_packet, output ready);
endinterface

>>> hdl/varint_length_prefixed_deframer_core.sv
// Varint length-prefixed deframer. Each received byte enters as one item on req_ch.
// A frame is a zero preamble byte, a base-128 little-endian varint payload length, a
// varint message type, then that many payload bytes. Every payload byte leaves as one
// result item on rsp_ch with the frame's type and a last mark on the final byte; an
// empty payload gives one empty-packet item. A nonzero preamble or a varint whose fifth
// byte still has its continuation bit set gives one error item, after which every
// further byte is accepted and dropped until reset. Other length and type bytes give no item.
// The block takes one byte per cycle unless the sink holds off the result register. A byte
// is held in the input register and then parsed into the result register, which drives
// rsp_ch; the parser waits while that register holds an untaken item. Ready drops
// only while the input register is full and the result register holds an item the sink
// has not taken yet.
// Depends on vlpd_pkg, vlpd_req_if, vlpd_rsp_if, vlpd_in_stage and vlpd_parser.
module varint_length_prefixed_deframer_core
   import vlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   vlpd_req_if.sink   req_ch,
   vlpd_rsp_if.source rsp_ch
);

   stage_type  stage;
   logic       advance;
   result_type result;

   // Input register: holds one received byte ahead of the parser.
   vlpd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_byte  (req_ch.in_byte),
      .req_ready (req_ch.ready),
      .advance   (advance),
      .stage     (stage)
   );

   // Frame state machine and result register.
   vlpd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .advance    (advance),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_result (result)
   );

   assign rsp_ch.out_kind       = result.kind;
   assign rsp_ch.payload_byte   = result.payload_byte;
   assign rsp_ch.message_type   = result.message_type;
   assign rsp_ch.last_of_packet = result.last_of_packet;

endmodule

>>> hdl/vlpd_in_stage.sv
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on vlpd_pkg.
module vlpd_in_stage
   import vlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_byte,
   output logic       req_ready,
   input  logic       advance,
   output stage_type  stage
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;

   // The register frees up in the same cycle the parser consumes it.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid ? 1'b1 : (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

>>> hdl/vlpd_parser.sv
// Frame parser of the deframer: frame state, one step per byte, and the result register.
// Depends on vlpd_pkg and the assertion macro header.
`include "varint_length_prefixed_deframer_core_macros.svh"

module vlpd_parser
   import vlpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result
);

   typedef enum logic [2:0] {
      PH_PREAMBLE = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_TYPE     = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_CLOSED   = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] accum_ff, accum_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] frame_type_ff, frame_type_in;
   logic [31:0] remaining_ff, remaining_in;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;

   logic        out_free;
   logic        res_valid;
   result_type  res;
   logic [4:0]  shamt;
   logic [31:0] merged;
   logic [2:0]  count_inc;
   logic [31:0] remaining_dec;

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance  = stage.valid && out_free;

   // Bit position of the current varint group: seven bits per byte already seen.
   always_comb begin
      case (count_ff)
         3'd0:    shamt = 5'd0;
         3'd1:    shamt = 5'd7;
         3'd2:    shamt = 5'd14;
         3'd3:    shamt = 5'd21;
         3'd4:    shamt = 5'd28;
         default: shamt = 5'd0;
      endcase
   end

   // Bits of a fifth group beyond bit 31 fall off the top.
   assign merged        = accum_ff | ({25'd0, stage.data[6:0]} << shamt);
   assign count_inc     = count_ff + 3'd1;
   assign remaining_dec = remaining_ff - 32'd1;

   always_comb begin
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      count_in      = count_ff;
      frame_type_in = frame_type_ff;
      remaining_in  = remaining_ff;
      res_valid     = 1'b0;
      res           = '{kind: KIND_PAYLOAD, payload_byte: 8'd0,
                        message_type: 32'd0, last_of_packet: 1'b0};
      case (phase_ff)
         PH_PREAMBLE: begin
            if (stage.data != PREAMBLE_BYTE) begin
               res_valid = 1'b1;
               res.kind  = KIND_BAD_PREAMBLE;
               phase_in  = PH_CLOSED;
            end else begin
               accum_in = 32'd0;
               count_in = 3'd0;
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH, PH_TYPE: begin
            if (!stage.data[7]) begin
               accum_in = 32'd0;
               count_in = 3'd0;
               if (phase_ff == PH_LENGTH) begin
                  remaining_in = merged;
                  phase_in     = PH_TYPE;
               end else begin
                  frame_type_in = merged;
                  if (remaining_ff == 32'd0) begin
                     res_valid          = 1'b1;
                     res.kind           = KIND_EMPTY;
                     res.message_type   = merged;
                     res.last_of_packet = 1'b1;
                     phase_in           = PH_PREAMBLE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end else if (count_inc >= VARINT_MAX_BYTES) begin
               accum_in  = merged;
               count_in  = count_inc;
               res_valid = 1'b1;
               res.kind  = KIND_OVERLONG;
               phase_in  = PH_CLOSED;
            end else begin
               accum_in = merged;
               count_in = count_inc;
            end
         end
         PH_PAYLOAD: begin
            remaining_in       = remaining_dec;
            res_valid          = 1'b1;
            res.kind           = KIND_PAYLOAD;
            res.payload_byte   = stage.data;
            res.message_type   = frame_type_ff;
            res.last_of_packet = (remaining_dec == 32'd0);
            if (remaining_dec == 32'd0) begin
               phase_in = PH_PREAMBLE;
            end
         end
         default: begin
            phase_in = PH_CLOSED;
         end
      endcase
   end

   assign out_valid_in = out_free ? (advance && res_valid) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_PREAMBLE;
         accum_ff      <= 32'd0;
         count_ff      <= 3'd0;
         frame_type_ff <= 32'd0;
         remaining_ff  <= 32'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff      <= phase_in;
            accum_ff      <= accum_in;
            count_ff      <= count_in;
            frame_type_ff <= frame_type_in;
            remaining_ff  <= remaining_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   `VLPD_ASSERT_NEXT(a_closed_sticky, phase_ff == PH_CLOSED, phase_ff == PH_CLOSED,
      "deframer left the closed phase without reset")
   `VLPD_ASSERT_NOW(a_count_bound, phase_ff != PH_CLOSED, count_ff <= 3'd4,
      "varint byte count went past four")
   `VLPD_ASSERT_NEXT(a_payload_emits, advance && phase_ff == PH_PAYLOAD, out_valid_ff,
      "payload byte consumed without a result")
   `VLPD_ASSERT_NOW(a_error_fields,
      out_valid_ff && (out_ff.kind == KIND_BAD_PREAMBLE || out_ff.kind == KIND_OVERLONG),
      out_ff.message_type == 32'd0 && !out_ff.last_of_packet && out_ff.payload_byte == 8'd0,
      "error result carries nonzero fields")

endmodule

>>> sim/varint_length_prefixed_deframer_core_test.sv
// Self-checking testbench of varint_length_prefixed_deframer_core: framed byte streams go in,
// and every payload, empty-packet and error item is checked against a cycle-free predictor.
// Depends on vlpd_pkg, vlpd_req_if, vlpd_rsp_if and the deframer RTL.
`timescale 1ns / 1ps

module varint_length_prefixed_deframer_core_test;
   import vlpd_pkg::*;

   // Random frames stop once this many bytes have gone in.
   localparam int RANDOM_BYTES  = 1900;
   // The watchdog gives up when a stretch without any handshake reaches this limit. The longest
   // legal quiet stretch is the forced receiver hold.
   localparam int QUIET_LIMIT   = 3000;
   // A result passes the input and result registers; this leaves margin for late items.
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 200;

   // Parser phases of the predictor.
   typedef enum logic [2:0] {
      AT_PREAMBLE,
      AT_LENGTH,
      AT_TYPE,
      AT_PAYLOAD,
      AT_CLOSED
   } parse_phase_type;

   // Ways to break the stream for the closing test.
   typedef enum int {
      BREAK_PREAMBLE,
      BREAK_LENGTH,
      BREAK_TYPE
   } break_kind_type;

   logic clock = 1'b0;
   logic reset;

   vlpd_req_if req_ch ();
   vlpd_rsp_if rsp_ch ();

   varint_length_prefixed_deframer_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // Predictor state, updated once per accepted byte.
   parse_phase_type pred_phase     = AT_PREAMBLE;
   logic [31:0]     pred_accum     = '0;
   int              pred_count     = 0;
   logic [31:0]     pred_type      = '0;
   logic [31:0]     pred_remaining = '0;
   bit              pred_closed    = 1'b0;

   // Results the block still owes, oldest first.
   result_type frame_results_due [$];
   // Bytes of the stream being assembled for the sender.
   logic [7:0] wire_bytes [$];

   result_type oldest_due;
   int  error_count    = 0;
   int  bytes_accepted = 0;
   int  quiet_cycles   = 0;
   int  hold_request   = 0;
   int  hold_left      = 0;
   bit  gaps_on        = 1'b1;
   bit  stalls_on      = 1'b1;

   // Idle stretch lengths come from three bands, picked 80, 15 and 5 percent of the time.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   function automatic void queue_result(kind_type kind, logic [7:0] data,
                                        logic [31:0] mtype, logic last);
      result_type item;
      item.kind           = kind;
      item.payload_byte   = data;
      item.message_type   = mtype;
      item.last_of_packet = last;
      frame_results_due.push_back(item);
   endfunction

   // Advances the predictor by one received byte and queues the item it causes, if any.
   // Once closed, every byte is dropped until reset.
   function automatic void deframe_step(logic [7:0] b);
      if (pred_closed) return;
      case (pred_phase)
         AT_PREAMBLE: begin
            if (b != PREAMBLE_BYTE) begin
               queue_result(KIND_BAD_PREAMBLE, 8'h00, 32'h0, 1'b0);
               pred_closed = 1'b1;
               pred_phase  = AT_CLOSED;
            end else begin
               pred_accum = '0;
               pred_count = 0;
               pred_phase = AT_LENGTH;
            end
         end
         AT_LENGTH, AT_TYPE: begin
            // Groups beyond bit 31 of a fifth byte fall off the 32-bit accumulator.
            pred_accum = pred_accum | (32'(b[6:0]) << (7 * pred_count));
            pred_count = pred_count + 1;
            if (b[7]) begin
               if (pred_count >= VARINT_MAX_BYTES) begin
                  queue_result(KIND_OVERLONG, 8'h00, 32'h0, 1'b0);
                  pred_closed = 1'b1;
                  pred_phase  = AT_CLOSED;
               end
            end else if (pred_phase == AT_LENGTH) begin
               pred_remaining = pred_accum;
               pred_accum     = '0;
               pred_count     = 0;
               pred_phase     = AT_TYPE;
            end else begin
               pred_type  = pred_accum;
               pred_accum = '0;
               pred_count = 0;
               if (pred_remaining == 0) begin
                  queue_result(KIND_EMPTY, 8'h00, pred_type, 1'b1);
                  pred_phase = AT_PREAMBLE;
               end else begin
                  pred_phase = AT_PAYLOAD;
               end
            end
         end
         AT_PAYLOAD: begin
            pred_remaining = pred_remaining - 1;
            queue_result(KIND_PAYLOAD, b, pred_type, pred_remaining == 0);
            if (pred_remaining == 0) pred_phase = AT_PREAMBLE;
         end
         default: begin
            pred_closed = 1'b1;
            pred_phase  = AT_CLOSED;
         end
      endcase
   endfunction

   // Appends a base-128 varint, padded with empty continuation groups up to min_len
   // bytes. With junk set, a fifth byte also carries bits above bit 31, which the
   // block must drop.
   function automatic void append_varint(logic [31:0] value, int min_len, bit junk);
      int len;
      logic [7:0] group;
      len = 1;
      while (len < 5 && (value >> (7 * len)) != 0) len++;
      if (min_len > len) len = (min_len > 5) ? 5 : min_len;
      for (int i = 0; i < len; i++) begin
         group = 8'((value >> (7 * i)) & 32'h7f);
         if (i < len - 1) begin
            group[7] = 1'b1;
         end else if (i == 4 && junk) begin
            group[6:4] = 3'($urandom_range(1, 7));
         end
         wire_bytes.push_back(group);
      end
   endfunction

   // Appends one well-formed frame with random payload bytes.
   function automatic void append_frame(int len, logic [31:0] mtype, int len_pad,
                                        int type_pad, bit junk);
      wire_bytes.push_back(PREAMBLE_BYTE);
      append_varint(32'(len), len_pad, junk);
      append_varint(mtype, type_pad, junk);
      repeat (len) wire_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Offers one byte, after a random gap, and holds it until the block takes it.
   // Entered and left at a falling edge; valid stays high for the next byte.
   task automatic offer_byte(input logic [7:0] b);
      int gap;
      gap = (gaps_on && $urandom_range(0, 99) < 25) ? idle_length() : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.in_byte = b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      deframe_step(b);
      bytes_accepted++;
      @(negedge clock);
   endtask

   task automatic offer_stream();
      while (wire_bytes.size() != 0) offer_byte(wire_bytes.pop_front());
      req_ch.valid = 1'b0;
   endtask

   // The sender pauses until every owed item has arrived and the pipeline is empty.
   task automatic wait_for_results();
      while (frame_results_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Empty packet of type zero, a two-byte payload of 0x00 and 0xFF under the largest
   // type, and a five-byte length and type whose top bits must be dropped.
   task automatic test_directed_frames();
      logic [7:0] script [0:24];
      script = '{8'h00, 8'h00, 8'h00,
                 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f, 8'h00, 8'hff,
                 8'h00, 8'h82, 8'h80, 8'h80, 8'h80, 8'h70,
                 8'h80, 8'h80, 8'h80, 8'h80, 8'h7f, 8'haa, 8'h55};
      foreach (script[i]) offer_byte(script[i]);
      req_ch.valid = 1'b0;
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while a long payload streams in without
   // gaps, so both internal registers fill and the block must drop ready.
   task automatic test_full_backpressure();
      gaps_on      = 1'b0;
      hold_request = LONG_HOLD;
      append_frame(48, 32'($urandom), 0, 0, 1'b0);
      offer_stream();
      wait_for_results();
      gaps_on = 1'b1;
   endtask

   // Well-formed frames with random sizes, types and encodings. Most payloads are short
   // so many frame boundaries are crossed; a few need two-byte lengths.
   task automatic test_random_frames();
      int pick;
      int len;
      logic [31:0] mtype;
      while (bytes_accepted < RANDOM_BYTES) begin
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 99);
         if (pick < 10) len = 0;
         else if (pick < 85) len = $urandom_range(1, 16);
         else if (pick < 97) len = $urandom_range(17, 130);
         else len = $urandom_range(131, 400);
         case ($urandom_range(0, 3))
            0: mtype = 32'($urandom_range(0, 127));
            1: mtype = 32'($urandom_range(128, 16383));
            2: mtype = 32'($urandom);
            default: mtype = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
         endcase
         append_frame(len, mtype,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0,
                      $urandom_range(0, 4) == 0);
         offer_stream();
         if ($urandom_range(0, 14) == 0) wait_for_results();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // Only one protocol error fits in a run, since the block stays closed until reset,
   // so the seed picks which one. A valid frame and random bytes follow it, and none of
   // them may produce an item.
   task automatic test_protocol_error();
      break_kind_type breakage;
      breakage = break_kind_type'($urandom_range(0, 2));
      case (breakage)
         BREAK_PREAMBLE: begin
            wire_bytes.push_back(8'($urandom_range(1, 255)));
         end
         BREAK_LENGTH: begin
            wire_bytes.push_back(PREAMBLE_BYTE);
            repeat (5) wire_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
         end
         default: begin
            wire_bytes.push_back(PREAMBLE_BYTE);
            append_varint(32'($urandom_range(0, 20)), $urandom_range(1, 5), 1'b0);
            repeat (5) wire_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
         end
      endcase
      append_frame(3, 32'($urandom), 0, 0, 1'b0);
      repeat (20) wire_bytes.push_back(8'($urandom_range(0, 255)));
      offer_stream();
   endtask

   // Receiver: random stalls, plus the long hold that a test may request.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (stalls_on && $urandom_range(0, 99) < 20) begin
            rsp_ch.ready = 1'b0;
            hold_left    = idle_length() - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Every accepted item is compared with the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (frame_results_due.size() == 0) begin
            $display("%0t: unexpected item, kind %0d byte %02h type %08h last %0b", $time,
                     rsp_ch.out_kind, rsp_ch.payload_byte, rsp_ch.message_type,
                     rsp_ch.last_of_packet);
            error_count++;
         end else begin
            oldest_due = frame_results_due.pop_front();
            if (rsp_ch.out_kind != oldest_due.kind
                || rsp_ch.payload_byte != oldest_due.payload_byte
                || rsp_ch.message_type != oldest_due.message_type
                || rsp_ch.last_of_packet != oldest_due.last_of_packet) begin
               $display("%0t: mismatch, expected kind %0d byte %02h type %08h last %0b",
                        $time, oldest_due.kind, oldest_due.payload_byte,
                        oldest_due.message_type, oldest_due.last_of_packet);
               $display("%0t:           actual kind %0d byte %02h type %08h last %0b",
                        $time, rsp_ch.out_kind, rsp_ch.payload_byte, rsp_ch.message_type,
                        rsp_ch.last_of_packet);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d items still owed", $time,
                  quiet_cycles, frame_results_due.size());
         $display("[varint_length_prefixed_deframer_core] ERROR");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_full_backpressure();
      test_random_frames();
      test_protocol_error();
      wait_for_results();

      if (error_count == 0) begin
         $display("[varint_length_prefixed_deframer_core] OK");
      end else begin
         $display("[varint_length_prefixed_deframer_core] ERROR");
      end
      $finish;
   end

endmodule
